// ===== hw/rtl/tpcs_pkg.sv =====
// Shared types and constants of the text page character segmenter.
package tpcs_pkg;

  // Encoding mode codes
  localparam logic MODE_UTF8 = 1'b0;
  localparam logic MODE_GB   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_ENCODING_MODE    = 2'd0;
  localparam logic [1:0] REG_CHARS_PER_PAGE   = 2'd1;
  localparam logic [1:0] REG_PAGE_BUFFER_BYTES = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Register reset values
  localparam logic [11:0] CPP_RESET = 12'd512;
  localparam logic [12:0] PBB_RESET = 13'd512;

  // Page buffer size clamp
  localparam logic [12:0] PBB_MIN = 13'd8;
  localparam logic [12:0] PBB_MAX = 13'd4096;

  // Byte codes
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Request queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // One classified request
  typedef struct packed {
    logic       is_end;      // end of input marker
    logic [7:0] data;
    logic       is_cr;
    logic       is_7bit;     // below 0x80
    logic       is_cont;     // 10xxxxxx
    logic [1:0] u8_cont;     // continuations of a UTF-8 lead, 0 when not a lead
    logic       gb_lead;     // 0x81..0xFE
    logic       gb_trail_ok; // 0x40..0xFE except 0x7F
  } item_t;

  // Configuration write bundle
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Queue status toward the back end
  typedef struct packed {
    logic            valid;
    logic [Q_CW-1:0] count;
  } q_status_t;

endpackage

// ===== hw/rtl/tpcs_front.sv =====
// Front end: takes requests and classifies each byte.
module tpcs_front
  import tpcs_pkg::*;
(
  input  logic       func,
  input  logic [7:0] in_byte,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  always_comb begin
    push_item.is_end      = func;
    push_item.data        = in_byte;
    push_item.is_cr       = (in_byte == CHAR_CR);
    push_item.is_7bit     = !in_byte[7];
    push_item.is_cont     = (in_byte[7:6] == 2'b10);
    push_item.u8_cont     = 2'd0;
    if (in_byte[7:5] == 3'b110) begin
      push_item.u8_cont = 2'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      push_item.u8_cont = 2'd2;
    end else if (in_byte[7:3] == 5'b11110) begin
      push_item.u8_cont = 2'd3;
    end
    push_item.gb_lead     = (in_byte >= 8'h81) && (in_byte <= 8'hFE);
    push_item.gb_trail_ok = (in_byte >= 8'h40) && (in_byte <= 8'hFE) && (in_byte != 8'h7F);
  end

endmodule

// ===== hw/rtl/tpcs_queue.sv =====
// Small request queue between front and back ends.
module tpcs_queue
  import tpcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     pop_item,
  output logic      full,
  output q_status_t status
);

  item_t           entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign full         = (count == Q_CW'(Q_DEPTH));
  assign status.valid = (count != '0);
  assign status.count = count;
  assign pop_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/tpcs_back.sv =====
// Back end: page state, configuration registers and result register.
module tpcs_back
  import tpcs_pkg::*;
#(
  parameter int RAW_PAGE_BYTES = 4096,
  parameter int BCW            = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_wr_t     cfg,
  input  q_status_t   q_status,
  input  item_t       item,
  output logic        pop,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic        char_done,
  output logic        page_closed_before,
  output logic        page_closed_after,
  output logic [11:0] chars_in_page,
  output logic [12:0] bytes_in_page,
  output logic [15:0] page_count,
  output logic [31:0] file_offset
);

  // configuration
  logic        mode;
  logic [11:0] cpp;
  logic [12:0] pbb;

  // page state
  logic [1:0]     pend;
  logic           gbp;
  logic [11:0]    chars;
  logic [BCW-1:0] bytes;
  logic [15:0]    pages;
  logic [31:0]    offset;

  logic [1:0]     pend_next;
  logic           gbp_next;
  logic [11:0]    chars_next;
  logic [BCW-1:0] bytes_next;
  logic [15:0]    pages_next;
  logic [31:0]    offset_next;

  logic [11:0]    eff_cpp;
  logic [12:0]    eff_pbb;
  logic [BCW-1:0] budget;
  logic [BCW:0]   pbb_m1;
  logic           limit_now;
  logic           lead_over;

  logic           fresh;
  logic [11:0]    c_chars;
  logic [BCW-1:0] c_bytes;
  logic [7:0]     r_byte;
  logic           r_valid;
  logic           r_done;
  logic           r_before;
  logic           r_after;

  assign pop = q_status.valid && (!res_valid || !res_stall);

  // effective limits
  always_comb begin
    eff_cpp = (cpp == '0) ? 12'd1 : cpp;
    if (pbb < PBB_MIN) begin
      eff_pbb = PBB_MIN;
    end else if (pbb > PBB_MAX) begin
      eff_pbb = PBB_MAX;
    end else begin
      eff_pbb = pbb;
    end
    budget    = (mode == MODE_GB) ? BCW'(RAW_PAGE_BYTES - 2) : BCW'(eff_pbb - 13'd4);
    pbb_m1    = (BCW+1)'(eff_pbb) - (BCW+1)'(1);
    limit_now = (chars >= eff_cpp) || (bytes >= budget);
    lead_over = ((BCW+1)'(bytes) + (BCW+1)'(item.u8_cont) + (BCW+1)'(1)) >= pbb_m1;
  end

  // per-request step
  always_comb begin
    pend_next   = pend;
    gbp_next    = gbp;
    c_chars     = chars;
    c_bytes     = bytes;
    pages_next  = pages;
    offset_next = offset;
    r_byte      = '0;
    r_valid     = 1'b0;
    r_done      = 1'b0;
    r_before    = 1'b0;
    r_after     = 1'b0;
    fresh       = 1'b0;
    if (item.is_end) begin
      pend_next = '0;
      gbp_next  = 1'b0;
      r_after   = 1'b1;
    end else begin
      offset_next = offset + 32'd1;
      fresh       = 1'b1;
      if (mode == MODE_UTF8 && pend != '0) begin
        if (item.is_cont) begin
          fresh     = 1'b0;
          r_byte    = item.data;
          r_valid   = 1'b1;
          c_bytes   = bytes + 1'b1;
          pend_next = pend - 1'b1;
          if (pend == 2'd1) begin
            r_done  = 1'b1;
            c_chars = chars + 1'b1;
          end
        end else begin
          pend_next = '0;   // abandoned, byte starts fresh
        end
      end else if (mode == MODE_GB && gbp) begin
        gbp_next = 1'b0;
        if (item.gb_trail_ok) begin
          fresh   = 1'b0;
          r_byte  = item.data;
          r_valid = 1'b1;
          c_bytes = bytes + 1'b1;
          r_done  = 1'b1;
          c_chars = chars + 1'b1;
        end
      end
      if (fresh) begin
        // close ahead of the byte: limit reached, or a UTF-8 lead that won't fit
        if (limit_now || (mode == MODE_UTF8 && !item.is_7bit && item.u8_cont != '0
                          && lead_over)) begin
          pages_next = pages + 1'b1;
          c_chars    = '0;
          c_bytes    = '0;
          r_before   = 1'b1;
        end
        if (item.is_cr) begin
          // dropped
        end else if (item.is_7bit) begin
          r_byte  = item.data;
          r_valid = 1'b1;
          c_bytes = c_bytes + 1'b1;
          r_done  = 1'b1;
          c_chars = c_chars + 1'b1;
        end else if (mode == MODE_UTF8) begin
          if (item.u8_cont != '0) begin
            r_byte    = item.data;
            r_valid   = 1'b1;
            c_bytes   = c_bytes + 1'b1;
            pend_next = item.u8_cont;
          end
        end else begin
          r_byte   = item.data;
          r_valid  = 1'b1;
          c_bytes  = c_bytes + 1'b1;
          gbp_next = item.gb_lead;
        end
      end
      if (pend_next == '0 && !gbp_next && ((c_chars >= eff_cpp) || (c_bytes >= budget))) begin
        r_after = 1'b1;
      end
    end
    if (r_after) begin
      pages_next = pages_next + 1'b1;
      chars_next = '0;
      bytes_next = '0;
    end else begin
      chars_next = c_chars;
      bytes_next = c_bytes;
    end
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_UTF8;
      cpp    <= CPP_RESET;
      pbb    <= PBB_RESET;
      pend   <= '0;
      gbp    <= 1'b0;
      chars  <= '0;
      bytes  <= '0;
      pages  <= '0;
      offset <= '0;
    end else begin
      // a mode write drops any open sequence
      if (cfg.we && cfg.index == REG_ENCODING_MODE) begin
        pend <= '0;
        gbp  <= 1'b0;
      end else if (pop) begin
        pend <= pend_next;
        gbp  <= gbp_next;
      end
      if (pop) begin
        chars  <= chars_next;
        bytes  <= bytes_next;
        pages  <= pages_next;
        offset <= offset_next;
      end
      if (cfg.we) begin
        unique case (cfg.index)
          REG_ENCODING_MODE:     mode <= cfg.data[0];
          REG_CHARS_PER_PAGE:    cpp <= cfg.data[11:0];
          REG_PAGE_BUFFER_BYTES: pbb <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte           <= r_byte;
      out_valid          <= r_valid;
      char_done          <= r_done;
      page_closed_before <= r_before;
      page_closed_after  <= r_after;
      chars_in_page      <= c_chars;
      bytes_in_page      <= c_bytes[12:0];
      page_count         <= pages_next;
      file_offset        <= offset_next;
    end
  end

endmodule

// ===== hw/rtl/text_page_char_segmenter_core.sv =====
// Top level of the text page character segmenter.
// Cuts a text byte stream into pages of whole characters, UTF-8/ASCII or GB
// double-byte, one request per byte (func 0) or end of input (func 1), and
// returns one result per request. Throughput is one request per clock while the
// result side is not stalled: the front end classifies each byte as it is
// accepted and pushes it into a four-entry queue; the back end pops one request
// per cycle unless res_stall holds the result, updates the page state and loads
// the result register. item_stall rises only when the queue is full, i.e. when
// the result side has been stalled long enough to back it up. rst clears the
// pointers, counters, configuration and res_valid but not the queue entries or
// result data; there is no clearing pass. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once; index 0 encoding mode (also drops
// an open sequence), 1 chars per page, 2 page buffer bytes. The GB byte budget
// is RAW_PAGE_BYTES - 2; the UTF-8 budget is the clamped buffer size minus four.
module text_page_char_segmenter_core
  import tpcs_pkg::*;
#(
  parameter int RAW_PAGE_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  func,
  input  logic [7:0]            in_byte,
  // result channel
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [7:0]            out_byte,
  output logic                  out_valid,
  output logic                  char_done,
  output logic                  page_closed_before,
  output logic                  page_closed_after,
  output logic [11:0]           chars_in_page,
  output logic [12:0]           bytes_in_page,
  output logic [15:0]           page_count,
  output logic [31:0]           file_offset
);

  // page byte counter must hold RAW_PAGE_BYTES - 1 in GB mode
  localparam int BCW = ($clog2(RAW_PAGE_BYTES) > 13) ? $clog2(RAW_PAGE_BYTES) : 13;

  logic      push;
  item_t     push_item;
  logic      q_full;
  logic      pop;
  item_t     pop_item;
  q_status_t q_status;
  cfg_wr_t   cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tpcs_front u_front (
    .func       (func),
    .in_byte    (in_byte),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  tpcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .status    (q_status)
  );

  tpcs_back #(
    .RAW_PAGE_BYTES (RAW_PAGE_BYTES),
    .BCW            (BCW)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .q_status           (q_status),
    .item               (pop_item),
    .pop                (pop),
    .res_valid          (res_valid),
    .res_stall          (res_stall),
    .out_byte           (out_byte),
    .out_valid          (out_valid),
    .char_done          (char_done),
    .page_closed_before (page_closed_before),
    .page_closed_after  (page_closed_after),
    .chars_in_page      (chars_in_page),
    .bytes_in_page      (bytes_in_page),
    .page_count         (page_count),
    .file_offset        (file_offset)
  );

`ifndef SYNTH
  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= Q_CW'(Q_DEPTH))
    else $error("request queue overfilled");

  // a request taken with no pop grows the queue by one
  a_q_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (q_status.count == $past(q_status.count) + 1'b1))
    else $error("request queue lost a request");

  // a finished character always writes a byte and leaves a nonzero count
  a_char_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && char_done) |-> (out_valid && chars_in_page != '0))
    else $error("character finished without a page byte");
`endif

endmodule
